// File: sv/rqrk_pkg.sv
package rqrk_pkg;

   localparam int unsigned DEPTH_DEF    = 16;
   localparam int unsigned ID_WIDTH_DEF = 16;

   localparam int unsigned PID_W   = 16;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic {
      OP_PUSH   = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic [PID_W-1:0]   proc_id;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [PID_W-1:0]   removed_id;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

endpackage

// File: sv/rqrk_if.sv
interface rqrk_req_if;
   logic             valid;
   logic             ready;
   rqrk_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rqrk_rsp_if;
   logic             valid;
   logic             ready;
   rqrk_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ready_queue_remove_by_key.sv
// Channel   Dir  Payload                                  Handshake
// req_chan  in   operation, proc_id                       valid / ready
// rsp_chan  out  status, removed_id, entry_count          valid / ready
//
// A push, or a remove on an empty queue, is answered straight from the idle
// state. A remove on a held queue scans it: the single read port of the
// entry RAM scans one position a cycle and the gap closes behind the match
// during the same pass. One item is worked on at a time; a new beat is
// taken once the result register is free or being drained. Reset empties
// the queue at once; the RAM content needs no clearing.
module ready_queue_remove_by_key #(
   parameter int unsigned DEPTH    = rqrk_pkg::DEPTH_DEF,
   parameter int unsigned ID_WIDTH = rqrk_pkg::ID_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rqrk_req_if.sink   req_chan,
   rqrk_rsp_if.source rsp_chan
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned KEY_W = (ID_WIDTH < rqrk_pkg::PID_W) ? ID_WIDTH : rqrk_pkg::PID_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic                     found_ff, found_in;
   logic [KEY_W-1:0]         hit_id_ff, hit_id_in;
   rqrk_pkg::status_type     res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rqrk_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [KEY_W-1:0]         ram_wr_data;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [KEY_W-1:0]         ram_rd_data;

   logic                     slot_free;
   logic                     req_beat;
   logic [KEY_W-1:0]         req_key;
   logic                     hit;
   logic                     last;
   logic                     found_now;

   rqrk_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign req_key        = KEY_W'(req_chan.data.proc_id);

   assign hit       = !found_ff && (ram_rd_data == key_ff);
   assign last      = (OCC_W'(pos_ff) == occ_ff - OCC_W'(1));
   assign found_now = found_ff || hit;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      hit_id_in     = hit_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = occ_ff[IDX_W-1:0];
      ram_wr_data   = req_key;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               key_in = req_key;
               if (req_chan.data.operation == rqrk_pkg::OP_PUSH) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.removed_id = '0;
                  if (occ_ff == OCC_W'(DEPTH)) begin
                     rsp_data_in.status = rqrk_pkg::ST_FULL;
                  end else begin
                     ram_wr_en          = 1'b1;
                     occ_in             = occ_ff + OCC_W'(1);
                     rsp_data_in.status = rqrk_pkg::ST_OK;
                  end
                  rsp_data_in.entry_count = rqrk_pkg::COUNT_W'(occ_in);
               end else if (occ_ff == '0) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = rqrk_pkg::ST_EMPTY;
                  rsp_data_in.removed_id  = '0;
                  rsp_data_in.entry_count = '0;
               end else begin
                  // read of position zero is under way
                  pos_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // shift each entry behind the match one place toward the head
            if (found_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(pos_ff - IDX_W'(1));
               ram_wr_data = ram_rd_data;
            end
            if (hit) begin
               hit_id_in = ram_rd_data;
            end
            found_in    = found_now;
            ram_rd_addr = IDX_W'(pos_ff + IDX_W'(1));
            if (last) begin
               if (found_now) begin
                  occ_in        = occ_ff - OCC_W'(1);
                  res_status_in = rqrk_pkg::ST_OK;
               end else begin
                  res_status_in = rqrk_pkg::ST_ABSENT;
               end
               state_in = S_DONE;
            end else begin
               pos_in = IDX_W'(pos_ff + IDX_W'(1));
            end
         end

         S_DONE: begin
            // hold until the result register can take the beat
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.removed_id  = (res_status_ff == rqrk_pkg::ST_OK)
                                         ? rqrk_pkg::PID_W'(hit_id_ff) : '0;
               rsp_data_in.entry_count = rqrk_pkg::COUNT_W'(occ_ff);
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      hit_id_ff     <= hit_id_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// File: sv/rqrk_ram.sv
module rqrk_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
